/* hw/rtl/bal_pkg.sv */
// ----------------------------------------------------------------------------
// bal_pkg
// shared types and codes for the bounded array list core
// ----------------------------------------------------------------------------
package bal_pkg;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_ERASE  = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_FULL         = 2'd1,
    ST_OUT_OF_RANGE = 2'd2,
    ST_NOT_FOUND    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_ERASE  = 2'd2,
    OP_READ   = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t   op;
    logic [7:0] pos;
  } cell_ctl_t;

  localparam int unsigned IN_BYTES  = 6;
  localparam int unsigned OUT_BYTES = 6;

endpackage

/* hw/rtl/bal_cell.sv */
// ----------------------------------------------------------------------------
// bal_cell
// one list position: holds an entry, shifts with its neighbors, taps a read
// ----------------------------------------------------------------------------
module bal_cell #(
  parameter int unsigned ENTRY_WIDTH = 32,
  parameter int unsigned POS         = 0
) (
  input  logic                   clk,
  input  bal_pkg::cell_ctl_t     ctl,
  input  logic [ENTRY_WIDTH-1:0] value,
  input  logic [ENTRY_WIDTH-1:0] left_data,
  input  logic [ENTRY_WIDTH-1:0] right_data,
  input  logic [ENTRY_WIDTH-1:0] rd_in,
  output logic [ENTRY_WIDTH-1:0] data,
  output logic [ENTRY_WIDTH-1:0] rd_out
);
  import bal_pkg::*;

  localparam logic [7:0] MY_POS = 8'(POS);

  logic [ENTRY_WIDTH-1:0] data_next;

  always_comb begin
    data_next = data;
    unique case (ctl.op)
      OP_INSERT: begin
        if (MY_POS > ctl.pos) begin
          data_next = left_data;
        end else if (MY_POS == ctl.pos) begin
          data_next = value;
        end
      end
      OP_ERASE: begin
        if (MY_POS >= ctl.pos) begin
          data_next = right_data;
        end
      end
      OP_READ, OP_HOLD: begin
        data_next = data;
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // read tap travels down the chain toward cell zero
  assign rd_out = rd_in | (((ctl.op == OP_READ) && (ctl.pos == MY_POS)) ? data
                                                                          : '0);

endmodule

/* hw/rtl/bounded_array_list_core.sv */
// ----------------------------------------------------------------------------
// bounded_array_list_core
// ordered list of up to CAPACITY entries with append, insert, erase and read
// ----------------------------------------------------------------------------
// commands arrive on the s_axis channel, one item per command, and each one
// gives exactly one result item on the m_axis channel with a status, the read
// word and the entry count after the command.
// the list lives in a row of cells, one entry per cell; insert and erase shift
// every cell past the index by one position in the same cycle, and the result
// is registered. throughput is one item per cycle as long as the receiver
// takes each result without stalling.
// the read word is gathered by an or chain along the cells, which sets the
// longest path for a large CAPACITY.
// reset clears the count and the output valid; the entry cells hold no reset
// value and are only read after they have been written.
// when the receiver stalls the result waits in the output register and
// s_axis_tready drops until it is taken; a new command is taken in the same
// cycle the pending result leaves.
// ----------------------------------------------------------------------------
module bounded_array_list_core #(
  parameter int unsigned CAPACITY    = 16,
  parameter int unsigned ENTRY_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // command [1:0], index [9:2], entry_value [41:10], zero [47:42]
  input  logic [bal_pkg::IN_BYTES*8-1:0]    s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // status [1:0], read_value [33:2], entry_count [41:34], zero [47:42]
  output logic [bal_pkg::OUT_BYTES*8-1:0]   m_axis_tdata
);
  import bal_pkg::*;

  localparam logic [8:0] CAP = 9'(CAPACITY);

  logic        accept;
  cmd_t        command;
  logic [7:0]  index;
  logic [31:0] entry_value;
  logic [63:0] value_wide;
  logic [ENTRY_WIDTH-1:0] value;

  logic [7:0]  count;
  logic [7:0]  count_next;
  status_t     status_next;
  cell_ctl_t   ctl;

  logic [ENTRY_WIDTH-1:0] cell_data [CAPACITY];
  logic [ENTRY_WIDTH-1:0] rd_chain  [CAPACITY+1];
  logic [63:0] rd_wide;

  status_t     status;
  logic [31:0] read_value;
  logic [7:0]  entry_count;
  logic        full;

  assign command     = cmd_t'(s_axis_tdata[1:0]);
  assign index       = s_axis_tdata[9:2];
  assign entry_value = s_axis_tdata[41:10];
  assign value_wide  = 64'(entry_value);
  assign value       = value_wide[ENTRY_WIDTH-1:0];

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign full          = {1'b0, count} >= CAP;

  always_comb begin
    status_next = ST_OK;
    count_next  = count;
    ctl.op      = OP_HOLD;
    ctl.pos     = index;
    unique case (command)
      CMD_APPEND: begin
        ctl.pos = count;
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ctl.op     = OP_INSERT;
          count_next = count + 8'd1;
        end
      end
      CMD_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else if (index > count) begin
          status_next = ST_OUT_OF_RANGE;
        end else begin
          ctl.op     = OP_INSERT;
          count_next = count + 8'd1;
        end
      end
      CMD_ERASE: begin
        if (index >= count) begin
          status_next = ST_NOT_FOUND;
        end else begin
          ctl.op     = OP_ERASE;
          count_next = count - 8'd1;
        end
      end
      CMD_READ: begin
        if ({1'b0, index} >= CAP) begin
          status_next = ST_OUT_OF_RANGE;
        end else if (index >= count) begin
          status_next = ST_NOT_FOUND;
        end else begin
          ctl.op = OP_READ;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
    if (!accept) begin
      ctl.op     = OP_HOLD;
      count_next = count;
    end
  end

  assign rd_chain[CAPACITY] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ENTRY_WIDTH-1:0] left_data;
    logic [ENTRY_WIDTH-1:0] right_data;
    if (i == 0) begin : g_first
      assign left_data = value;
    end else begin : g_mid_left
      assign left_data = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_data = cell_data[i];
    end else begin : g_mid_right
      assign right_data = cell_data[i+1];
    end
    bal_cell #(
      .ENTRY_WIDTH (ENTRY_WIDTH),
      .POS         (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .value      (value),
      .left_data  (left_data),
      .right_data (right_data),
      .rd_in      (rd_chain[i+1]),
      .data       (cell_data[i]),
      .rd_out     (rd_chain[i])
    );
  end

  assign rd_wide = 64'(rd_chain[0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status      <= status_next;
      read_value  <= rd_wide[31:0];
      entry_count <= count_next;
    end
  end

  assign m_axis_tdata = {6'd0, entry_count, read_value, status};

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the bounded array list core
// ----------------------------------------------------------------------------
// a queue of commands is built up front: a short directed run over the edge
// cases, then shaped random traffic that grows, shrinks and churns the list.
// a clocked driver offers the commands on s_axis and predicts each accepted
// one with its own copy of the list; a clocked monitor takes results from
// m_axis and checks them field by field in order. both sides idle at random,
// the receiver holds off once for a long stretch, and the sender once waits
// until every result is back before going on.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bal_pkg::*;

  localparam int unsigned CAPACITY   = 16;
  localparam int unsigned RAND_ITEMS = 1150;
  localparam int unsigned LIMIT      = 200000;
  localparam int unsigned IDLE_PCT   = 19;

  typedef struct {
    cmd_t        cmd;
    logic [7:0]  index;
    logic [31:0] value;
    bit          wait_drain;
  } list_cmd_t;

  typedef struct {
    status_t     status;
    logic [31:0] read_value;
    logic [7:0]  entry_count;
  } list_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;

  list_cmd_t    cmd_queue[$];
  list_result_t list_expected[$];
  list_cmd_t    offer_cmd;
  logic [31:0]  list_words [CAPACITY];
  int unsigned  list_len = 0;
  int unsigned  gen_len = 0;
  int unsigned  in_count = 0;
  int unsigned  out_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  fail_count = 0;
  int unsigned  hold_left = 0;
  bit           hold_done = 1'b0;
  bit           accepting;
  bit           may_send;
  int unsigned  status_seen [4];
  int unsigned  full_seen = 0;
  int unsigned  directed_items = 0;

  bounded_array_list_core #(
    .CAPACITY    (CAPACITY),
    .ENTRY_WIDTH (32)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // list behavior, applied in acceptance order
  function automatic list_result_t list_apply(cmd_t cmd, logic [7:0] idx, logic [31:0] val);
    list_result_t r;
    r.status     = ST_OK;
    r.read_value = '0;
    case (cmd)
      CMD_APPEND: begin
        if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          list_words[list_len] = val;
          list_len++;
        end
      end
      CMD_INSERT: begin
        if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (idx > list_len) begin
          r.status = ST_OUT_OF_RANGE;
        end else begin
          for (int unsigned i = list_len; i > idx; i--) list_words[i] = list_words[i-1];
          list_words[idx] = val;
          list_len++;
        end
      end
      CMD_ERASE: begin
        if (idx >= list_len) begin
          r.status = ST_NOT_FOUND;
        end else begin
          for (int unsigned i = idx; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
        end
      end
      default: begin
        if (idx >= CAPACITY) begin
          r.status = ST_OUT_OF_RANGE;
        end else if (idx >= list_len) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.read_value = list_words[idx];
        end
      end
    endcase
    r.entry_count = list_len[7:0];
    return r;
  endfunction

  // queue a command and follow the list length it leaves behind
  task automatic queue_cmd(cmd_t cmd, int unsigned idx, logic [31:0] val, bit drain = 1'b0);
    list_cmd_t c;
    c.cmd        = cmd;
    c.index      = idx[7:0];
    c.value      = val;
    c.wait_drain = drain;
    cmd_queue.push_back(c);
    case (cmd)
      CMD_APPEND: if (gen_len < CAPACITY) gen_len++;
      CMD_INSERT: if (gen_len < CAPACITY && idx <= gen_len) gen_len++;
      CMD_ERASE:  if (idx < gen_len) gen_len--;
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return 32'h0000_0000;
    if (roll < 16) return 32'hffff_ffff;
    return $urandom;
  endfunction

  // driver: predicts on acceptance, then offers the next pending item
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      accepting = s_axis_tvalid && s_axis_tready;
      if (accepting) begin
        list_expected.push_back(list_apply(offer_cmd.cmd, offer_cmd.index, offer_cmd.value));
        in_count <= in_count + 1;
      end
      if (!s_axis_tvalid || accepting) begin
        may_send = 1'b0;
        if (cmd_queue.size() != 0) begin
          if (cmd_queue[0].wait_drain) begin
            may_send = !accepting && in_count == out_count;
          end else if (in_count >= 600 && in_count < 850) begin
            may_send = 1'b1;
          end else begin
            may_send = $urandom_range(0, 99) >= IDLE_PCT;
          end
        end
        if (may_send) begin
          offer_cmd = cmd_queue.pop_front();
          s_axis_tdata  <= {6'b0, offer_cmd.value, offer_cmd.index, offer_cmd.cmd};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (out_count >= in_count) begin
          $display("%0t: result with nothing pending, data %h", $realtime, m_axis_tdata);
          fail_count++;
        end else begin
          list_result_t e;
          e = list_expected.pop_front();
          out_count <= out_count + 1;
          status_seen[e.status]++;
          if (e.entry_count == CAPACITY) full_seen++;
          if (m_axis_tdata[1:0] != e.status) begin
            $display("%0t: status expected %s got %0d", $realtime, e.status.name(),
                     m_axis_tdata[1:0]);
            fail_count++;
          end
          if (m_axis_tdata[33:2] != e.read_value) begin
            $display("%0t: read_value expected %h got %h", $realtime, e.read_value,
                     m_axis_tdata[33:2]);
            fail_count++;
          end
          if (m_axis_tdata[41:34] != e.entry_count) begin
            $display("%0t: entry_count expected %0d got %0d", $realtime, e.entry_count,
                     m_axis_tdata[41:34]);
            fail_count++;
          end
        end
      end
      // long hold-off once, then a stretch with no idling
      if (hold_left > 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && out_count >= 400) begin
        hold_done     <= 1'b1;
        hold_left     <= 90;
        m_axis_tready <= 1'b0;
      end else if (out_count >= 600 && out_count < 850) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= $urandom_range(0, 99) >= IDLE_PCT;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("%0t: timeout, %0d items in, %0d results out", $realtime, in_count, out_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned bias;
    int unsigned roll;
    int unsigned idx;
    cmd_t        cmd;

    // directed: empty list, bounds, shifting, full list
    queue_cmd(CMD_READ, 0, '0);
    queue_cmd(CMD_READ, 255, '0);
    queue_cmd(CMD_READ, CAPACITY, '0);
    queue_cmd(CMD_ERASE, 0, '0);
    queue_cmd(CMD_INSERT, 1, 32'h1234_5678);
    queue_cmd(CMD_INSERT, 0, 32'hffff_ffff);
    queue_cmd(CMD_APPEND, 255, 32'h0000_0000);
    queue_cmd(CMD_INSERT, 2, 32'ha5a5_a5a5);
    queue_cmd(CMD_INSERT, 1, 32'h5a5a_5a5a);
    queue_cmd(CMD_ERASE, 4, '0);
    queue_cmd(CMD_ERASE, 1, '0);
    while (gen_len < CAPACITY) queue_cmd(CMD_APPEND, 0, $urandom);
    queue_cmd(CMD_APPEND, 0, 32'hdead_beef);
    queue_cmd(CMD_INSERT, 200, 32'hdead_beef);
    queue_cmd(CMD_READ, CAPACITY - 1, '0);
    queue_cmd(CMD_ERASE, CAPACITY - 1, '0);
    queue_cmd(CMD_ERASE, 0, '0);
    directed_items = cmd_queue.size();

    // random: phases that grow, shrink or churn the list, with some noise
    bias = 2;
    for (int unsigned n = 0; n < RAND_ITEMS; n++) begin
      if (n % 120 == 0) bias = $urandom_range(0, 2);
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        queue_cmd(cmd_t'($urandom_range(0, 3)), $urandom_range(0, 255), pick_value(),
                  n == 700);
      end else begin
        roll = $urandom_range(0, 99);
        case (bias)
          0:       cmd = roll < 35 ? CMD_APPEND : roll < 70 ? CMD_INSERT :
                         roll < 80 ? CMD_ERASE : CMD_READ;
          1:       cmd = roll < 10 ? CMD_APPEND : roll < 20 ? CMD_INSERT :
                         roll < 70 ? CMD_ERASE : CMD_READ;
          default: cmd = cmd_t'(roll % 4);
        endcase
        roll = $urandom_range(0, 99);
        case (cmd)
          CMD_APPEND: idx = $urandom_range(0, 255);
          CMD_INSERT: idx = roll < 10 ? gen_len + 1 : roll < 20 ? gen_len :
                            $urandom_range(0, gen_len);
          CMD_ERASE:  idx = (gen_len == 0 || roll < 8) ? gen_len :
                            $urandom_range(0, gen_len - 1);
          default:    idx = roll < 5 ? CAPACITY : roll < 10 ? CAPACITY - 1 :
                            roll < 15 ? gen_len :
                            gen_len == 0 ? 0 : $urandom_range(0, gen_len - 1);
        endcase
        queue_cmd(cmd, idx, pick_value(), n == 700);
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (cmd_queue.size() != 0 || s_axis_tvalid || in_count != out_count) @(negedge clk);
    repeat (10) @(posedge clk);
    if (in_count != out_count || list_expected.size() != 0) begin
      $display("%0t: %0d results never arrived", $realtime, list_expected.size());
      fail_count++;
    end

    $display("%0d commands (%0d directed), %0d results checked, %0d results at full list",
             in_count, directed_items, out_count, full_seen);
    $display("status mix: ok %0d, full %0d, out of range %0d, not found %0d",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_OUT_OF_RANGE],
             status_seen[ST_NOT_FOUND]);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/bal_pkg.sv
hw/rtl/bal_cell.sv
hw/rtl/bounded_array_list_core.sv
test/tb.sv
